FILE: rtl/slrg_pkg.sv
// ----------------------------------------------------------------------------
// slrg_pkg - shared types and constants of the shuffled LCG generator
// Generator constants, table geometry, word layouts and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package slrg_pkg;

	localparam int unsigned VALUE_W  = 31;
	localparam int unsigned MULT_W   = 15;
	localparam int unsigned PROD_W   = VALUE_W + MULT_W;
	localparam int unsigned FRAC_W   = 32;
	localparam int unsigned SEED_W   = 32;

	localparam logic [MULT_W-1:0]  MULTIPLIER   = 15'd16807;
	localparam logic [VALUE_W-1:0] MODULUS      = 31'h7FFF_FFFF;
	localparam logic [FRAC_W-1:0]  FRACTION_MAX = 32'd4294966780;

	// Table size must stay a power of two: the index is the top bits of
	// the shuffle output.
	localparam int unsigned TABLE_SIZE = 32;
	localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
	localparam int unsigned WARMUP     = TABLE_SIZE + 8;
	localparam int unsigned CNT_W      = $clog2(WARMUP);

	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 64;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [FRAC_W-1:0]  frac_t;

	typedef struct packed {
		logic             load_start;
		logic             start_one;
		logic             mul;
		logic             red;
		logic             tab_we;
		logic             tab_seed;
		logic [IDX_W-1:0] tab_addr;
		logic             load_shuf_gen;
		logic             load_shuf_rd;
		logic             load_out;
		logic             clear_needs;
	} slrg_cmd_t;

	typedef struct packed {
		logic needs_seed;
		logic degenerate;
		logic out_full;
	} slrg_status_t;

endpackage : slrg_pkg

`default_nettype wire

FILE: rtl/slrg_datapath.sv
// ----------------------------------------------------------------------------
// slrg_datapath - generator, shuffle table and output register
// Holds the seed, the generator value, the shuffle output and the table;
// performs one multiply per step and reduces the registered product modulo 2^31-1 in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module slrg_datapath (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 seed_we,
	input  wire  signed [slrg_pkg::SEED_W-1:0]  seed_wdata,
	input  wire  slrg_pkg::slrg_cmd_t           cmd,
	output slrg_pkg::slrg_status_t              status,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output slrg_pkg::value_t                    out_value,
	output slrg_pkg::frac_t                     out_fraction
);
	import slrg_pkg::*;

	logic signed [SEED_W-1:0] seed_q;
	logic                     needs_q;
	value_t                   gen_q;
	value_t                   shuf_q;
	value_t                   rd_q;
	logic [PROD_W-1:0]        prod_s1;
	value_t                   table_q [TABLE_SIZE];

	logic [SEED_W-1:0]  neg_seed;
	value_t             start;
	logic [VALUE_W:0]   fold;
	value_t             reduced;
	logic [IDX_W-1:0]   addr;
	frac_t              frac_raw;
	frac_t              frac_clip;

	// Negative seeds start at -seed; the most negative code wraps and counts
	// as non-negative.
	always_comb begin
		neg_seed = 32'd0 - seed_q;
		if (seed_q[SEED_W-1] && (seed_q != 32'sh8000_0000) && !cmd.start_one) begin
			start = neg_seed[VALUE_W-1:0];
		end else begin
			start = value_t'(1);
		end
	end

	// 2^31 == 1 mod 2^31-1: fold the high part onto the low, one subtract.
	always_comb begin
		fold = {1'b0, prod_s1[VALUE_W-1:0]}
			+ {{(VALUE_W+1-MULT_W){1'b0}}, prod_s1[PROD_W-1:VALUE_W]};
		if (fold >= {1'b0, MODULUS}) begin
			reduced = VALUE_W'(fold - {1'b0, MODULUS});
		end else begin
			reduced = fold[VALUE_W-1:0];
		end
	end

	assign addr = cmd.tab_seed ? cmd.tab_addr : shuf_q[VALUE_W-1 -: IDX_W];

	// 2v >= 2^31-1 exactly when v >= 2^30, and 2v is even, so +1 sets bit 0.
	always_comb begin
		frac_raw = {shuf_q, shuf_q[VALUE_W-1]};
		frac_clip = (frac_raw > FRACTION_MAX) ? FRACTION_MAX : frac_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q    <= -32'sd1;
			needs_q   <= 1'b1;
			gen_q     <= '0;
			shuf_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (seed_we) begin
				seed_q  <= seed_wdata;
				needs_q <= 1'b1;
			end else if (cmd.clear_needs) begin
				needs_q <= 1'b0;
			end
			if (cmd.load_start) begin
				gen_q <= start;
			end else if (cmd.red) begin
				gen_q <= reduced;
			end
			if (cmd.load_shuf_gen) begin
				shuf_q <= gen_q;
			end else if (cmd.load_shuf_rd) begin
				shuf_q <= rd_q;
			end
			if (cmd.load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= gen_q * MULTIPLIER;
		end
		if (cmd.load_out) begin
			out_value    <= shuf_q;
			out_fraction <= frac_clip;
		end
	end

	// Table: read the old entry and write the new generator value in the same cycle.
	always_ff @(posedge clk) begin
		if (cmd.tab_we) begin
			rd_q          <= table_q[addr];
			table_q[addr] <= reduced;
		end
	end

	assign status.needs_seed = needs_q;
	assign status.degenerate = (gen_q == '0) || (shuf_q == '0);
	assign status.out_full   = out_valid;

endmodule : slrg_datapath

`default_nettype wire

FILE: rtl/slrg_ctrl.sv
// ----------------------------------------------------------------------------
// slrg_ctrl - sequencer of the shuffled LCG generator
// Accepts one request word, runs the warm-up when seeding is due, then the
// step, table swap and, for a request without discard, the output load.
// ----------------------------------------------------------------------------
`default_nettype none

module slrg_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire                     in_discard,
	input  wire                     out_ready,
	input  wire  slrg_pkg::slrg_status_t status,
	output slrg_pkg::slrg_cmd_t     cmd
);
	import slrg_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_RED,
		ST_SEED_DONE,
		ST_STEP_MUL,
		ST_STEP_RED,
		ST_SWAP,
		ST_OUT
	} state_t;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WARMUP - 1);
	localparam logic [CNT_W-1:0] CNT_FILL = CNT_W'(WARMUP - TABLE_SIZE);

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             discard_q;
	logic             accept;
	logic [CNT_W-1:0] fill_idx;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign fill_idx = CNT_LAST - cnt_q;

	always_comb begin
		cmd = '0;
		cmd.tab_addr = fill_idx[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept && (status.needs_seed || status.degenerate)) begin
					cmd.load_start = 1'b1;
					cmd.start_one  = !status.needs_seed;
				end
			end
			ST_SEED_MUL: cmd.mul = 1'b1;
			ST_SEED_RED: begin
				cmd.red      = 1'b1;
				cmd.tab_seed = 1'b1;
				cmd.tab_we   = (cnt_q >= CNT_FILL);
			end
			ST_SEED_DONE: begin
				cmd.load_shuf_gen = 1'b1;
				cmd.clear_needs   = 1'b1;
			end
			ST_STEP_MUL: cmd.mul = 1'b1;
			ST_STEP_RED: begin
				cmd.red    = 1'b1;
				cmd.tab_we = 1'b1;
			end
			ST_SWAP: cmd.load_shuf_rd = 1'b1;
			ST_OUT: cmd.load_out = !discard_q && (!status.out_full || out_ready);
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			discard_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						discard_q <= in_discard;
						cnt_q     <= '0;
						if (status.needs_seed || status.degenerate) begin
							state_q <= ST_SEED_MUL;
						end else begin
							state_q <= ST_STEP_MUL;
						end
					end
				end
				ST_SEED_MUL: state_q <= ST_SEED_RED;
				ST_SEED_RED: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_SEED_DONE;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_SEED_MUL;
					end
				end
				ST_SEED_DONE: state_q <= ST_STEP_MUL;
				ST_STEP_MUL:  state_q <= ST_STEP_RED;
				ST_STEP_RED:  state_q <= ST_SWAP;
				ST_SWAP:      state_q <= ST_OUT;
				ST_OUT: begin
					// hold until the output register can take the word, or leave on a discard
					if (discard_q || !status.out_full || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule : slrg_ctrl

`default_nettype wire

FILE: rtl/shuffled_lcg_random_generator.sv
// ----------------------------------------------------------------------------
// shuffled_lcg_random_generator - minimal standard generator with shuffle
// Park-Miller x <- 16807*x mod (2^31-1) behind a 32-entry Bays-Durham table.
// ----------------------------------------------------------------------------
// A request word (tdata bit 0 = discard) advances the generator once and,
// unless discard is set, returns one result word holding the shuffled 31-bit
// value and its Q0.32 fraction. The block works on one request at a time: a
// normal request passes through accept, multiply, modulo reduce and table
// read/write, shuffle update and output load, and every step goes through
// the single registered 31x15 multiplier followed by a reduction stage and
// one registered table port. After reset, after a seed write, or when the
// generator or shuffle output has collapsed to zero, the request first runs
// 40 warm-up steps plus a shuffle output load. The last 32 warm-up steps
// fill the table, so no table entry is read before it is written. Write the
// seed only while the block is idle; a negative seed other than -2^31 starts
// the generator at -seed, anything else starts it at 1, and a collapse
// without a new seed restarts it at 1. The result register decouples the
// output side: a new request is taken while a result still waits there.
// ----------------------------------------------------------------------------
`default_nettype none

module shuffled_lcg_random_generator (
	input  wire                                     clk,
	input  wire                                     arst_n,
	// seed register
	input  wire                                     seed_we,
	input  wire  signed [slrg_pkg::SEED_W-1:0]      seed_wdata,
	// request stream
	input  wire                                     s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire         [slrg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [0] discard, [7:1] zero
	// result stream
	output logic                                    m_axis_tvalid,
	input  wire                                     m_axis_tready,
	output logic        [slrg_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // [30:0] value,
	                                                               // [62:31] fraction, [63] zero
);
	import slrg_pkg::*;

	slrg_cmd_t    cmd;
	slrg_status_t status;
	value_t       out_value;
	frac_t        out_fraction;

	// sequencer: owns the request handshake and the warm-up count
	slrg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_discard (s_axis_tdata[0]),
		.out_ready  (m_axis_tready),
		.status     (status),
		.cmd        (cmd)
	);

	// generator, table and result register
	slrg_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.seed_we      (seed_we),
		.seed_wdata   (seed_wdata),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_value    (out_value),
		.out_fraction (out_fraction)
	);

	// pack the result word, pad the top bit with zero
	assign m_axis_tdata = {1'b0, out_fraction, out_value};

endmodule : shuffled_lcg_random_generator

`default_nettype wire

FILE: rtl/slrg_checker.sv
// ----------------------------------------------------------------------------
// slrg_checker - port-level checks of the shuffled LCG generator
// Watches the request and result streams and the packing of a result word.
// ----------------------------------------------------------------------------
`default_nettype none

module slrg_checker (
	input wire                                     clk,
	input wire                                     arst_n,
	input wire                                     s_axis_tvalid,
	input wire                                     s_axis_tready,
	input wire                                     m_axis_tvalid,
	input wire                                     m_axis_tready,
	input wire         [slrg_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import slrg_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// one request at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while busy");

	// fraction stays below one
	a_frac_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[62:31] <= FRACTION_MAX)
		else $error("fraction above clip level");

	// fraction is the value doubled with the rounding bit, or the clip level
	a_frac_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[62:32] == m_axis_tdata[30:0]
			&& m_axis_tdata[31] == m_axis_tdata[30])
			|| m_axis_tdata[62:31] == FRACTION_MAX)
		else $error("fraction does not match value");

endmodule : slrg_checker

bind shuffled_lcg_random_generator slrg_checker u_slrg_checker (.*);

`default_nettype wire
